>>> rtl/core/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Shared widths, register indexes and the divider stage record of the
// single-sided ray/triangle intersection block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rti_pkg;

	// Coordinate width; the three coordinates of a vertex pack into 3*CW bits.
	localparam int CW    = 21;
	localparam int EW    = CW + 1;          // edges and origin offsets
	localparam int NPW   = 2 * EW;          // cross product terms of the normal
	localparam int NW    = NPW + 1;         // normal components
	localparam int MPW   = EW + CW;         // cross product terms of s x d
	localparam int MW    = MPW + 1;         // components of s x d
	localparam int AW    = NW + EW + 2;     // dot product accumulators
	localparam int DVW   = AW - 1;          // divisor and remainder width

	// Operands wider than a narrow multiplier are split into a low and a high part.
	localparam int NL    = NW / 2;
	localparam int NH    = NW - NL;
	localparam int NLX   = (NL + 1 > NH) ? NL + 1 : NH;
	localparam int PDW   = NLX + CW;        // normal part times direction
	localparam int PSW   = NLX + EW;        // normal part times origin offset
	localparam int ML    = MW / 2;
	localparam int MH    = MW - ML;
	localparam int MLX   = (ML + 1 > MH) ? ML + 1 : MH;
	localparam int PEW   = MLX + EW;        // s x d part times edge

	localparam int FW    = 16;              // fractional bits of the quotients
	localparam int QTW   = 32;              // distance quotient width
	localparam int QBW   = FW + 1;          // barycentric quotient width
	localparam logic [QBW-1:0] ONE_Q16 = QBW'(1) << FW;

	// Configuration port.
	localparam int REG_W  = 3 * CW;
	localparam int EPS_W  = 16;
	localparam int DATA_W = 64;
	localparam int RIDX_W = 2;
	localparam int PAW    = RIDX_W + 3;
	localparam logic [EPS_W-1:0]  EPS_RST  = EPS_W'(1);
	localparam logic [RIDX_W-1:0] REG_VTX0 = RIDX_W'(0);
	localparam logic [RIDX_W-1:0] REG_VTX1 = RIDX_W'(1);
	localparam logic [RIDX_W-1:0] REG_VTX2 = RIDX_W'(2);
	localparam logic [RIDX_W-1:0] REG_EPS  = RIDX_W'(3);

	// One request as it travels through the divider stages.
	typedef struct packed {
		logic             pass;
		logic             sat;
		logic [DVW-1:0]   det;
		logic [DVW-1:0]   rem_t;
		logic [QTW-1:0]   q_t;
		logic [FW-1:0]    tlo;
		logic [DVW-1:0]   rem_u;
		logic [DVW-1:0]   rem_v;
		logic             ub;
		logic             vb;
		logic [QBW-1:0]   q_u;
		logic [QBW-1:0]   q_v;
		logic [QTW-1:0]   cd;
	} dstg_t;

endpackage

>>> rtl/core/rti_geom.sv
// ----------------------------------------------------------------------------
// rti_geom
// Seven-stage datapath forming det, u, v and t, the culling tests and the
// starting remainders for the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rti_geom (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_vld,
	input  logic signed [rti_pkg::CW-1:0]       org [3],
	input  logic signed [rti_pkg::CW-1:0]       dir [3],
	input  logic [rti_pkg::QTW-1:0]             cd,
	input  logic [rti_pkg::REG_W-1:0]           vtx [3],
	input  logic [rti_pkg::EPS_W-1:0]           eps,
	output logic                                out_vld,
	output rti_pkg::dstg_t                      req
);

	localparam int CW    = rti_pkg::CW;
	localparam int EW    = rti_pkg::EW;
	localparam int NPW   = rti_pkg::NPW;
	localparam int NW    = rti_pkg::NW;
	localparam int MPW   = rti_pkg::MPW;
	localparam int MW    = rti_pkg::MW;
	localparam int AW    = rti_pkg::AW;
	localparam int DVW   = rti_pkg::DVW;
	localparam int NL    = rti_pkg::NL;
	localparam int ML    = rti_pkg::ML;
	localparam int PDW   = rti_pkg::PDW;
	localparam int PSW   = rti_pkg::PSW;
	localparam int PEW   = rti_pkg::PEW;
	localparam int FW    = rti_pkg::FW;
	localparam int QTW   = rti_pkg::QTW;
	localparam int EPS_W = rti_pkg::EPS_W;

	logic signed [EW-1:0]  e1c [3];
	logic signed [EW-1:0]  e2c [3];
	logic signed [NPW-1:0] np_q [6];
	logic signed [NW-1:0]  n_q [3];

	logic signed [EW-1:0]  s_s1 [3];
	logic signed [CW-1:0]  d_s1 [3];
	logic signed [MPW-1:0] mp_s2 [6];
	logic signed [EW-1:0]  s_s2 [3];
	logic signed [CW-1:0]  d_s2 [3];
	logic signed [MW-1:0]  m_s3 [3];
	logic signed [PDW-1:0] ndl_s3 [3];
	logic signed [PDW-1:0] ndh_s3 [3];
	logic signed [PSW-1:0] nsl_s3 [3];
	logic signed [PSW-1:0] nsh_s3 [3];
	logic signed [AW-1:0]  nd_s4 [3];
	logic signed [AW-1:0]  ns_s4 [3];
	logic signed [PEW-1:0] me2l_s4 [3];
	logic signed [PEW-1:0] me2h_s4 [3];
	logic signed [PEW-1:0] me1l_s4 [3];
	logic signed [PEW-1:0] me1h_s4 [3];
	logic signed [AW-1:0]  me2_s5 [3];
	logic signed [AW-1:0]  me1_s5 [3];
	logic signed [AW-1:0]  det_s5, t_s5;
	logic signed [AW-1:0]  det_s6, t_s6, u_s6, v_s6;
	logic [QTW-1:0]        cd_s1, cd_s2, cd_s3, cd_s4, cd_s5, cd_s6;
	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	rti_pkg::dstg_t        req_c, req_s7;

	for (genvar k = 0; k < 3; k++) begin : g_k
		localparam int K1 = (k + 1) % 3;
		localparam int K2 = (k + 2) % 3;
		logic signed [CW-1:0]  v0c;
		logic signed [NL:0]    nl;
		logic signed [NW-NL-1:0] nh;
		logic signed [ML:0]    ml;
		logic signed [MW-ML-1:0] mh;

		assign v0c    = $signed(vtx[0][k*CW +: CW]);
		assign e1c[k] = EW'($signed(vtx[1][k*CW +: CW])) - EW'(v0c);
		assign e2c[k] = EW'($signed(vtx[2][k*CW +: CW])) - EW'(v0c);
		assign nl     = $signed({1'b0, n_q[k][NL-1:0]});
		assign nh     = $signed(n_q[k][NW-1:NL]);
		assign ml     = $signed({1'b0, m_s3[k][ML-1:0]});
		assign mh     = $signed(m_s3[k][MW-1:ML]);

		// The normal follows the vertex registers through np_q and then n_q.
		always_ff @(posedge clk) begin
			np_q[2*k]     <= NPW'(e1c[K1]) * NPW'(e2c[K2]);
			np_q[2*k + 1] <= NPW'(e1c[K2]) * NPW'(e2c[K1]);
			n_q[k]        <= NW'(np_q[2*k]) - NW'(np_q[2*k + 1]);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				s_s1[k]       <= EW'(org[k]) - EW'(v0c);
				d_s1[k]       <= dir[k];
				mp_s2[2*k]     <= MPW'(s_s1[K1]) * MPW'(d_s1[K2]);
				mp_s2[2*k + 1] <= MPW'(s_s1[K2]) * MPW'(d_s1[K1]);
				s_s2[k]       <= s_s1[k];
				d_s2[k]       <= d_s1[k];
				m_s3[k]       <= MW'(mp_s2[2*k]) - MW'(mp_s2[2*k + 1]);
				ndl_s3[k]     <= PDW'(nl) * PDW'(d_s2[k]);
				ndh_s3[k]     <= PDW'(nh) * PDW'(d_s2[k]);
				nsl_s3[k]     <= PSW'(nl) * PSW'(s_s2[k]);
				nsh_s3[k]     <= PSW'(nh) * PSW'(s_s2[k]);
				nd_s4[k]      <= (AW'(ndh_s3[k]) <<< NL) + AW'(ndl_s3[k]);
				ns_s4[k]      <= (AW'(nsh_s3[k]) <<< NL) + AW'(nsl_s3[k]);
				me2l_s4[k]    <= PEW'(ml) * PEW'(e2c[k]);
				me2h_s4[k]    <= PEW'(mh) * PEW'(e2c[k]);
				me1l_s4[k]    <= PEW'(ml) * PEW'(e1c[k]);
				me1h_s4[k]    <= PEW'(mh) * PEW'(e1c[k]);
				me2_s5[k]     <= (AW'(me2h_s4[k]) <<< ML) + AW'(me2l_s4[k]);
				me1_s5[k]     <= (AW'(me1h_s4[k]) <<< ML) + AW'(me1l_s4[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s5 <= -(nd_s4[0] + nd_s4[1] + nd_s4[2]);
			t_s5   <= ns_s4[0] + ns_s4[1] + ns_s4[2];
			det_s6 <= det_s5;
			t_s6   <= t_s5;
			u_s6   <= me2_s5[0] + me2_s5[1] + me2_s5[2];
			v_s6   <= -(me1_s5[0] + me1_s5[1] + me1_s5[2]);
			cd_s1  <= cd;
			cd_s2  <= cd_s1;
			cd_s3  <= cd_s2;
			cd_s4  <= cd_s3;
			cd_s5  <= cd_s4;
			cd_s6  <= cd_s5;
			req_s7 <= req_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// Culling and inside tests; any failure makes the ray a miss.
	always_comb begin
		logic signed [AW-1:0] epsx;
		logic signed [AW-1:0] uv;
		logic                 fail;
		epsx = $signed({{(AW-EPS_W){1'b0}}, eps});
		uv   = u_s6 + v_s6;
		fail = (det_s6 < epsx) || (det_s6 == '0) || u_s6[AW-1] || (det_s6 < u_s6) ||
			v_s6[AW-1] || (det_s6 < uv) || !(epsx < t_s6);
		req_c.pass  = !fail;
		req_c.sat   = {{FW{1'b0}}, t_s6[AW-2:FW]} >= det_s6[DVW-1:0];
		req_c.det   = det_s6[DVW-1:0];
		req_c.rem_t = {{FW{1'b0}}, t_s6[AW-2:FW]};
		req_c.q_t   = '0;
		req_c.tlo   = t_s6[FW-1:0];
		req_c.rem_u = {1'b0, u_s6[AW-2:1]};
		req_c.rem_v = {1'b0, v_s6[AW-2:1]};
		req_c.ub    = u_s6[0];
		req_c.vb    = v_s6[0];
		req_c.q_u   = '0;
		req_c.q_v   = '0;
		req_c.cd    = cd_s6;
	end

	assign out_vld = vld_s7;
	assign req     = req_s7;

endmodule

>>> rtl/core/rti_div.sv
// ----------------------------------------------------------------------------
// rti_div
// Restoring divider pipeline, one quotient bit per stage: 32 bits of distance
// and, in the first 17 stages, both barycentric quotients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rti_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  rti_pkg::dstg_t req,
	output logic           out_vld,
	output rti_pkg::dstg_t res
);

	localparam int DVW = rti_pkg::DVW;
	localparam int QTW = rti_pkg::QTW;
	localparam int QBW = rti_pkg::QBW;
	localparam int FW  = rti_pkg::FW;

	rti_pkg::dstg_t st_s  [QTW];
	logic           vld_s [QTW];

	for (genvar j = 0; j < QTW; j++) begin : g_stg
		rti_pkg::dstg_t prv, nxt;
		logic           prv_vld;
		logic           bt;

		if (j == 0) begin : g_first
			assign prv     = req;
			assign prv_vld = in_vld;
		end else begin : g_next
			assign prv     = st_s[j-1];
			assign prv_vld = vld_s[j-1];
		end

		// Numerator bits of the distance: the low bits of t, then zeros.
		if (j < FW) begin : g_tbit
			assign bt = prv.tlo[FW-1-j];
		end else begin : g_tzero
			assign bt = 1'b0;
		end

		always_comb begin
			logic [DVW:0] sh_t, sh_u, sh_v, df_t, df_u, df_v;
			logic         ge_t, ge_u, ge_v;
			nxt   = prv;
			sh_t  = {prv.rem_t, bt};
			df_t  = sh_t - {1'b0, prv.det};
			ge_t  = sh_t >= {1'b0, prv.det};
			nxt.rem_t = ge_t ? df_t[DVW-1:0] : sh_t[DVW-1:0];
			nxt.q_t   = {prv.q_t[QTW-2:0], ge_t};
			sh_u  = {prv.rem_u, (j == 0) ? prv.ub : 1'b0};
			sh_v  = {prv.rem_v, (j == 0) ? prv.vb : 1'b0};
			df_u  = sh_u - {1'b0, prv.det};
			df_v  = sh_v - {1'b0, prv.det};
			ge_u  = sh_u >= {1'b0, prv.det};
			ge_v  = sh_v >= {1'b0, prv.det};
			if (j < QBW) begin
				nxt.rem_u = ge_u ? df_u[DVW-1:0] : sh_u[DVW-1:0];
				nxt.rem_v = ge_v ? df_v[DVW-1:0] : sh_v[DVW-1:0];
				nxt.q_u   = {prv.q_u[QBW-2:0], ge_u};
				nxt.q_v   = {prv.q_v[QBW-2:0], ge_v};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[j] <= nxt;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= prv_vld;
			end
		end
	end

	assign out_vld = vld_s[QTW-1];
	assign res     = st_s[QTW-1];

endmodule

>>> rtl/core/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Throughput: one ray per clock while no stall holds the pipeline; the
// 32-stage distance divider sets the depth. A stalled output with a valid
// result waiting holds the whole pipeline; the input stall follows it directly.
// Reset clears all valid bits, sets the vertices to zero and epsilon to one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_triangle_intersect (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [rti_pkg::PAW-1:0]            paddr,
	input  logic [rti_pkg::DATA_W-1:0]         pwdata,
	output logic [rti_pkg::DATA_W-1:0]         prdata,
	output logic                               pready,

	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [rti_pkg::CW-1:0]      origin_x,
	input  logic signed [rti_pkg::CW-1:0]      origin_y,
	input  logic signed [rti_pkg::CW-1:0]      origin_z,
	input  logic signed [rti_pkg::CW-1:0]      dir_x,
	input  logic signed [rti_pkg::CW-1:0]      dir_y,
	input  logic signed [rti_pkg::CW-1:0]      dir_z,
	input  logic [rti_pkg::QTW-1:0]            closest_dist,

	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               is_hit,
	output logic [rti_pkg::QTW-1:0]            hit_dist,
	output logic [rti_pkg::QBW-1:0]            bary_u,
	output logic [rti_pkg::QBW-1:0]            bary_v
);

	localparam int REG_W  = rti_pkg::REG_W;
	localparam int EPS_W  = rti_pkg::EPS_W;
	localparam int DATA_W = rti_pkg::DATA_W;
	localparam int PAW    = rti_pkg::PAW;
	localparam int QTW    = rti_pkg::QTW;
	localparam int QBW    = rti_pkg::QBW;

	// Configuration registers. The three vertices feed the normal directly,
	// so they must only change while no request is in flight.
	logic [REG_W-1:0] vtx_q [3];
	logic [EPS_W-1:0] eps_q;

	// Pipeline control: every stage advances together unless a finished
	// result is waiting at the output and the receiver holds it back.
	logic                en;
	logic                geo_vld, div_vld;
	rti_pkg::dstg_t      geo_req, div_res;
	logic                hit_c;

	logic                out_vld_q;
	logic                hit_q;
	logic [QTW-1:0]      dist_q;
	logic [QBW-1:0]      u_q, v_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_q[0] <= '0;
			vtx_q[1] <= '0;
			vtx_q[2] <= '0;
			eps_q    <= rti_pkg::EPS_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[PAW-1:3])
				rti_pkg::REG_VTX0: vtx_q[0] <= pwdata[REG_W-1:0];
				rti_pkg::REG_VTX1: vtx_q[1] <= pwdata[REG_W-1:0];
				rti_pkg::REG_VTX2: vtx_q[2] <= pwdata[REG_W-1:0];
				rti_pkg::REG_EPS:  eps_q    <= pwdata[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[PAW-1:3])
			rti_pkg::REG_VTX0: prdata = {{(DATA_W-REG_W){1'b0}}, vtx_q[0]};
			rti_pkg::REG_VTX1: prdata = {{(DATA_W-REG_W){1'b0}}, vtx_q[1]};
			rti_pkg::REG_VTX2: prdata = {{(DATA_W-REG_W){1'b0}}, vtx_q[2]};
			rti_pkg::REG_EPS:  prdata = {{(DATA_W-EPS_W){1'b0}}, eps_q};
			default:           prdata = '0;
		endcase
	end

	assign en       = !(out_vld_q && out_stall);
	assign in_stall = !en;

	// Stages one to seven: edges, normal, s x d, the four dot products and
	// the culling tests, ending in the divider's starting remainders.
	rti_geom u_geom (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.org     ('{origin_x, origin_y, origin_z}),
		.dir     ('{dir_x, dir_y, dir_z}),
		.cd      (closest_dist),
		.vtx     (vtx_q),
		.eps     (eps_q),
		.out_vld (geo_vld),
		.req     (geo_req)
	);

	// Thirty-two divider stages, one quotient bit each.
	rti_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (geo_vld),
		.req     (geo_req),
		.out_vld (div_vld),
		.res     (div_res)
	);

	// A saturated distance can never be nearer, so it is simply a miss.
	assign hit_c = div_res.pass && !div_res.sat && (div_res.q_t < div_res.cd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q  <= hit_c;
			dist_q <= hit_c ? div_res.q_t : '0;
			u_q    <= hit_c ? div_res.q_u : '0;
			v_q    <= hit_c ? div_res.q_v : '0;
		end
	end

	assign out_valid = out_vld_q;
	assign is_hit    = hit_q;
	assign hit_dist  = dist_q;
	assign bary_u    = u_q;
	assign bary_v    = v_q;

	// A miss must present all-zero fields.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_hit) |-> (hit_dist == '0 && bary_u == '0 && bary_v == '0))
		else $error("miss result carries non-zero fields");

	// Barycentric quotients of an accepted hit stay within the triangle.
	a_bary_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_hit) |->
		((QBW+1)'(bary_u) + (QBW+1)'(bary_v) <= (QBW+1)'(rti_pkg::ONE_Q16)))
		else $error("barycentric sum exceeds one");

	// A saturated distance is never reported as a hit.
	a_no_sat_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_hit) |-> (hit_dist != '1))
		else $error("hit reported at saturated distance");

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the single-sided ray/triangle intersection block.
// Each accepted ray is run through an exact 128-bit model of the culling
// test, the barycentric bounds, the distance test and the divisions. The
// result is queued and then compared field by field with the block's output.
// The rays are aimed at points inside randomly placed triangles and mixed
// with full-range noise. Both handshakes idle and stall in random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int CW     = rti_pkg::CW;
	localparam int PAW    = rti_pkg::PAW;
	localparam int DATA_W = rti_pkg::DATA_W;
	localparam int QTW    = rti_pkg::QTW;
	localparam int QBW    = rti_pkg::QBW;
	localparam int RIDX_W = rti_pkg::RIDX_W;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		bit         hit;
		bit [31:0]  hdist;
		bit [16:0]  u;
		bit [16:0]  v;
	} hit_rec_t;

	// Holds the current triangle and threshold, predicts the outcome of every
	// accepted ray and compares the block's results against the oldest one.
	class hit_board;
		logic [62:0]  vtx[3];
		logic [15:0]  eps;
		hit_rec_t     pending_hits[$];
		int           errors;

		function new();
			vtx[0] = '0;
			vtx[1] = '0;
			vtx[2] = '0;
			eps = rti_pkg::EPS_RST;
			errors = 0;
		endfunction

		function wide_t coord(int i, int k);
			logic signed [CW-1:0] c;
			c = vtx[i][k*CW +: CW];
			return wide_t'(c);
		endfunction

		function void cross3(input wide_t a[3], input wide_t b[3], output wide_t r[3]);
			r[0] = a[1] * b[2] - a[2] * b[1];
			r[1] = a[2] * b[0] - a[0] * b[2];
			r[2] = a[0] * b[1] - a[1] * b[0];
		endfunction

		function wide_t dot3(input wide_t a[3], input wide_t b[3]);
			return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
		endfunction

		function hit_rec_t predict_hit(logic signed [CW-1:0] o[3],
				logic signed [CW-1:0] d[3], logic [31:0] cd);
			hit_rec_t r;
			wide_t p0[3], e1[3], e2[3], n[3], s[3], dw[3], m[3];
			wide_t det, u, v, t, e;
			logic [127:0] q;
			logic [31:0] dq;
			r = '{0, 0, 0, 0};
			for (int k = 0; k < 3; k++) begin
				p0[k] = coord(0, k);
				e1[k] = coord(1, k) - p0[k];
				e2[k] = coord(2, k) - p0[k];
				s[k] = wide_t'(o[k]) - p0[k];
				dw[k] = wide_t'(d[k]);
			end
			cross3(e1, e2, n);
			e = {112'b0, eps};
			det = -dot3(n, dw);
			if (det < e || det == 0)
				return r;
			cross3(s, dw, m);
			u = dot3(m, e2);
			if (u < 0 || det < u)
				return r;
			v = -dot3(m, e1);
			if (v < 0 || det < u + v)
				return r;
			t = dot3(n, s);
			if (!(e < t))
				return r;
			q = (128'(t) << 16) / 128'(det);
			dq = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
			if (dq >= cd)
				return r;
			r.hit = 1;
			r.hdist = dq;
			q = (128'(u) << 16) / 128'(det);
			r.u = q[16:0];
			q = (128'(v) << 16) / 128'(det);
			r.v = q[16:0];
			return r;
		endfunction

		function void note_ray(logic signed [CW-1:0] o[3], logic signed [CW-1:0] d[3],
				logic [31:0] cd);
			pending_hits.push_back(predict_hit(o, d, cd));
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch on %s: got %0h, expected %0h", what, got, want);
			errors++;
		endtask

		task check(bit hit, bit [31:0] hdist, bit [16:0] u, bit [16:0] v);
			hit_rec_t w;
			if (pending_hits.size() == 0) begin
				report("unexpected result", 32'd1, 32'd0);
			end else begin
				w = pending_hits.pop_front();
				if (hit != w.hit) report("is_hit", 32'(hit), 32'(w.hit));
				if (hdist != w.hdist) report("hit_dist", hdist, w.hdist);
				if (u != w.u) report("bary_u", 32'(u), 32'(w.u));
				if (v != w.v) report("bary_v", 32'(v), 32'(w.v));
			end
		endtask
	endclass

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  psel = 0, penable = 0, pwrite = 0;
	logic [PAW-1:0]        paddr = '0;
	logic [DATA_W-1:0]     pwdata = '0;
	logic [DATA_W-1:0]     prdata;
	logic                  pready;
	logic                  in_valid = 0;
	logic                  in_stall;
	logic signed [CW-1:0]  origin_x = '0, origin_y = '0, origin_z = '0;
	logic signed [CW-1:0]  dir_x = '0, dir_y = '0, dir_z = '0;
	logic [QTW-1:0]        closest_dist = '0;
	logic                  out_valid;
	logic                  out_stall = 0;
	logic                  is_hit;
	logic [QTW-1:0]        hit_dist;
	logic [QBW-1:0]        bary_u, bary_v;

	hit_board  sb = new();
	bit        idling = 1;
	int        stall_left = 0;

	ray_triangle_intersect dut (.*);

	always #5 clk = ~clk;

	// The watchdog allows for far more than the slowest correct run.
	initial begin
		#20ms;
		$display("testbench NOT OK");
		$finish;
	end

	// The result side: results are checked at the edge where they are taken,
	// and the stall is raised in bursts while idling is still allowed.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check(is_hit, hit_dist, bary_u, bary_v);
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1;
		end else if (arst_n && idling && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 10);
			out_stall <= 1;
		end else begin
			out_stall <= 0;
		end
	end

	// A register write has a setup and then an access phase; the model copy
	// follows once the access has completed.
	task write_reg(logic [RIDX_W-1:0] idx, logic [63:0] value);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (idx == rti_pkg::REG_EPS)
			sb.eps = value[15:0];
		else
			sb.vtx[idx] = value[62:0];
	endtask

	// One request is held until the block takes it; a gap may follow.
	task send_ray(logic signed [CW-1:0] o[3], logic signed [CW-1:0] d[3], logic [31:0] cd);
		in_valid <= 1;
		origin_x <= o[0];
		origin_y <= o[1];
		origin_z <= o[2];
		dir_x <= d[0];
		dir_y <= d[1];
		dir_z <= d[2];
		closest_dist <= cd;
		do @(posedge clk); while (in_stall);
		sb.note_ray(o, d, cd);
		if (idling && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// Before touching the registers every result must be back; the extra
	// cycles cover the pipeline depth.
	task drain();
		in_valid <= 0;
		while (sb.pending_hits.size() != 0) @(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	function logic signed [CW-1:0] rnd_coord(int span);
		return CW'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	function logic [63:0] pack_vertex(logic signed [CW-1:0] p[3]);
		return {1'($urandom), p[2], p[1], p[0]};
	endfunction

	// A triangle with coordinates small enough that any aimed direction fits.
	task place_triangle(output logic signed [CW-1:0] tv[3][3]);
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++)
				tv[i][k] = rnd_coord(1 << 17);
			write_reg(RIDX_W'(i), pack_vertex(tv[i]));
		end
	endtask

	// Mostly rays aimed at a point inside the triangle, from either side, with
	// the direction shortened by a random shift; the rest is full-range noise.
	task random_ray(logic signed [CW-1:0] tv[3][3]);
		logic signed [CW-1:0] o[3], d[3];
		logic [31:0] cd;
		int a, b, sh;
		wide_t p;
		if ($urandom_range(0, 4) == 0) begin
			for (int k = 0; k < 3; k++) begin
				o[k] = CW'($urandom);
				d[k] = CW'($urandom);
			end
			cd = $urandom;
		end else begin
			a = $urandom_range(0, 65536);
			b = $urandom_range(0, 65536 - a);
			sh = $urandom_range(0, 4);
			for (int k = 0; k < 3; k++) begin
				o[k] = rnd_coord(1 << 18);
				p = wide_t'(tv[0][k]) + ((wide_t'(a) * (tv[1][k] - tv[0][k])
					+ wide_t'(b) * (tv[2][k] - tv[0][k])) >>> 16);
				d[k] = CW'((p - o[k]) >>> sh);
			end
			case ($urandom_range(0, 3))
				0: cd = 32'hFFFF_FFFF;
				1: cd = $urandom;
				default: cd = $urandom_range(0, 1 << 22);
			endcase
		end
		send_ray(o, d, cd);
	endtask

	initial begin
		logic signed [CW-1:0] tv[3][3];
		logic signed [CW-1:0] o[3], d[3];
		logic signed [CW-1:0] ext[2];
		logic [15:0] eps_set[8];

		ext[0] = -21'sd1048576;
		ext[1] = 21'sd1048575;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part. With the reset triangle every ray sees a zero
		// determinant, so the field extremes all give a miss.
		for (int i = 0; i < 8; i++) begin
			for (int k = 0; k < 3; k++) begin
				o[k] = ext[(i >> k) & 1];
				d[k] = ext[~(i >> k) & 1];
			end
			send_ray(o, d, i[0] ? 32'hFFFF_FFFF : 32'h0);
		end
		drain();

		// A triangle in the z = 0 plane seen from above: a hit inside, hits on
		// a vertex and an edge, back face, not nearer, a saturating distance from
		// a ray that barely moves, and a ray that starts in the plane.
		write_reg(rti_pkg::REG_VTX0, {1'b1, 21'sd0, 21'sd0, 21'sd0});
		write_reg(rti_pkg::REG_VTX1, {1'b0, 21'sd0, 21'sd0, 21'sd4096});
		write_reg(rti_pkg::REG_VTX2, {1'b0, 21'sd0, 21'sd4096, 21'sd0});
		for (int k = 0; k < 3; k++)
			for (int i = 0; i < 3; i++)
				tv[i][k] = '0;
		tv[1][0] = 21'sd4096;
		tv[2][1] = 21'sd4096;
		o = '{1024, 1024, 2048};
		d = '{0, 0, -1024};
		send_ray(o, d, 32'hFFFF_FFFF);
		send_ray(o, d, 32'h0002_0000);
		send_ray(o, d, 32'h0001_0000);
		d = '{0, 0, 1024};
		send_ray(o, d, 32'hFFFF_FFFF);
		o = '{0, 0, 524288};
		d = '{0, 0, -1};
		send_ray(o, d, 32'hFFFF_FFFF);
		o = '{2048, 2048, 1024};
		d = '{0, 0, -1024};
		send_ray(o, d, 32'hFFFF_FFFF);
		o = '{4096, 0, 1024};
		send_ray(o, d, 32'hFFFF_FFFF);
		o = '{0, 0, 0};
		send_ray(o, d, 32'hFFFF_FFFF);
		drain();

		// Random phases, each with its own triangle and threshold, including
		// a zero threshold on a flat triangle, the largest threshold, and a
		// triangle at the coordinate extremes. The last phase runs without
		// any idling.
		eps_set = '{16'd1, 16'd0, 16'hFFFF, 16'd0, 16'd37, 16'd1, 16'd0, 16'd1};
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(rti_pkg::REG_EPS, {48'b0, ph == 4 ? 16'($urandom) : eps_set[ph]});
			place_triangle(tv);
			if (ph == 3) begin
				// Collinear vertices: the determinant is zero for every ray.
				for (int k = 0; k < 3; k++) begin
					tv[1][k] = CW'(tv[0][k] + 16);
					tv[2][k] = CW'(tv[0][k] + 32);
				end
				write_reg(rti_pkg::REG_VTX1, pack_vertex(tv[1]));
				write_reg(rti_pkg::REG_VTX2, pack_vertex(tv[2]));
			end
			if (ph == 5) begin
				for (int i = 0; i < 3; i++) begin
					for (int k = 0; k < 3; k++)
						tv[i][k] = ext[(i + k) & 1];
					tv[i][i] = ~tv[i][i];
					write_reg(RIDX_W'(i), pack_vertex(tv[i]));
				end
			end
			idling = (ph != 7);
			for (int n = 0; n < 150; n++) begin
				random_ray(tv);
				// Once, the sender holds off until every result is back.
				if (ph == 2 && n == 75) begin
					in_valid <= 0;
					while (sb.pending_hits.size() != 0) @(posedge clk);
				end
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending_hits.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
